// ===== rtl/core/bdgn_pkg.sv =====
// ----------------------------------------------------------------------------
// bdgn_pkg
// Shared types, constants and helper functions of the box decoder with
// greedy non-maximum suppression.
// ----------------------------------------------------------------------------
package bdgn_pkg;

   // Default sizes of the candidate store and of the detection list.
   localparam int CAPACITY_DEF = 1024;
   localparam int MAX_OUT_DEF  = 64;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;

   // Field widths.
   localparam int COORD_W = 24;
   localparam int CONF_W  = 16;
   localparam int SCORE_W = 16;
   localparam int DIM_W   = 12;
   localparam int DET_W   = 7;
   // A clamped box edge lies in 0 .. 4095 * 1024, so extents fit 22 bits.
   localparam int EXT_W   = 22;
   localparam int AREA_W  = 2 * EXT_W;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 16;

   // Register reset values.
   localparam logic [SCORE_W-1:0] SCORE_THR_RST   = 16'd32768;
   localparam logic [SCORE_W-1:0] OVERLAP_THR_RST = 16'd29491;
   localparam logic [DET_W-1:0]   MAX_DET_RST     = 7'd10;
   localparam logic [DIM_W-1:0]   IMAGE_DIM_RST   = 12'd320;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_AW-1:0] {
      CSR_SCORE_THR   = 3'd0,
      CSR_OVERLAP_THR = 3'd1,
      CSR_MAX_DET     = 3'd2,
      CSR_IMAGE_W     = 3'd3,
      CSR_IMAGE_H     = 3'd4
   } csr_index_type;

   // Configuration seen by the front and back parts.
   typedef struct packed {
      logic [SCORE_W-1:0] score_thr;
      logic [SCORE_W-1:0] overlap_thr;
      logic [DET_W-1:0]   max_det;
      logic [DIM_W-1:0]   image_w;
      logic [DIM_W-1:0]   image_h;
   } cfg_type;

   // One decoded box with its score, as held in the candidate store.
   typedef struct packed {
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] x2;
      logic signed [COORD_W-1:0] y2;
      logic [SCORE_W-1:0]        score;
   } box_type;

   // One queue entry: a box to store and/or the end of a frame.
   typedef struct packed {
      logic    keep;
      logic    last_anchor;
      box_type box;
   } cand_type;

   // Sequencer states of the back part.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INS_CHK,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_N_SCAN,
      ST_N_LOAD,
      ST_N_PUSH,
      ST_N_TAKE,
      ST_N_AREA,
      ST_N_JRD,
      ST_N_J1,
      ST_N_J2,
      ST_N_J3,
      ST_N_J4,
      ST_N_J5,
      ST_N_END,
      ST_N_FINAL,
      ST_N_EMPTY
   } state_type;

   // Confidence in Q0.16: a value near 0..1 is taken as a probability,
   // anything else as a logit through a piecewise linear sigmoid.
   function automatic logic [SCORE_W-1:0] conf_of(input logic signed [CONF_W-1:0] raw);
      logic [CONF_W:0]   mag;
      logic [CONF_W+1:0] y;
      logic [CONF_W+1:0] r;
      logic [SCORE_W-1:0] res;
      if (raw >= -16'sd2 && raw <= 16'sd258) begin
         if (raw < 0) begin
            res = '0;
         end else if (raw >= 16'sd256) begin
            res = '1;
         end else begin
            res = {raw[7:0], 8'h00};
         end
      end else begin
         mag = raw[CONF_W-1] ? (CONF_W+1)'(-$signed({raw[CONF_W-1], raw}))
                             : {1'b0, raw};
         if (mag < 17'd256) begin
            y = {1'b0, mag} * 18'd64 + 18'd32768;
         end else if (mag < 17'd608) begin
            y = {1'b0, mag} * 18'd32 + 18'd40960;
         end else if (mag < 17'd1280) begin
            y = {1'b0, mag} * 18'd8 + 18'd55296;
         end else begin
            y = 18'd65536;
         end
         r = raw[CONF_W-1] ? 18'd65536 - y : y;
         res = (r > 18'd65535) ? '1 : r[SCORE_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/bdgn_queue.sv =====
// ----------------------------------------------------------------------------
// bdgn_queue
// Short first-in first-out queue of decoded candidates between the front
// and back parts.
// ----------------------------------------------------------------------------
module bdgn_queue
   import bdgn_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cand_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output cand_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cand_type        slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/bdgn_front.sv =====
// ----------------------------------------------------------------------------
// bdgn_front
// Accepts anchor requests, computes the confidence, scales normalized
// boxes, decodes and clamps them, and queues the survivors.
// ----------------------------------------------------------------------------
module bdgn_front
   import bdgn_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_anchor_a0,
   input  logic signed [COORD_W-1:0] req_anchor_a1,
   input  logic signed [COORD_W-1:0] req_anchor_a2,
   input  logic signed [COORD_W-1:0] req_anchor_a3,
   input  logic signed [CONF_W-1:0]  req_confidence_raw,
   input  logic                      req_final_anchor,
   input  logic                      q_full,
   output logic                      q_push,
   output cand_type                  q_data
);

   localparam int DW = COORD_W + 2;

   logic                      s1_v_ff;
   logic signed [COORD_W-1:0] s1_a_ff [4];
   logic [SCORE_W-1:0]        s1_conf_ff;
   logic                      s1_last_ff;

   logic                      s2_v_ff;
   logic signed [COORD_W-1:0] s2_a_ff [4];
   logic [SCORE_W-1:0]        s2_conf_ff;
   logic                      s2_keep_ff;
   logic                      s2_last_ff;

   logic                      norm;
   logic signed [COORD_W-1:0] scaled [4];
   logic                      s1_free, s2_free, s2_drop;
   logic                      req_take;

   logic signed [DW-1:0]      wq, hq;
   logic signed [DW-1:0]      ctr [4];
   logic signed [DW-1:0]      crn [4];
   logic signed [DW-1:0]      ctr_c [4];
   logic signed [DW-1:0]      crn_c [4];
   logic                      ctr_ok, crn_ok;

   // Stage one: register the request with its confidence.
   assign req_take  = req_valid && s1_free;
   assign req_stall = !s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_free) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_a_ff[0] <= req_anchor_a0;
         s1_a_ff[1] <= req_anchor_a1;
         s1_a_ff[2] <= req_anchor_a2;
         s1_a_ff[3] <= req_anchor_a3;
         s1_conf_ff <= conf_of(req_confidence_raw);
         s1_last_ff <= req_final_anchor;
      end
   end

   // A box whose four values all lie in 0 .. 1.5 is scaled to pixels.
   always_comb begin
      logic [DIM_W-1:0]          dim;
      logic [COORD_W-2:0]        prod;
      norm = 1'b1;
      for (int k = 0; k < 4; k++) begin
         if (s1_a_ff[k] < 0 || s1_a_ff[k] > 24'sd1536) begin
            norm = 1'b0;
         end
      end
      for (int k = 0; k < 4; k++) begin
         dim  = (k % 2 == 0) ? cfg.image_w : cfg.image_h;
         prod = (COORD_W-1)'(s1_a_ff[k][10:0] * dim);
         scaled[k] = norm ? $signed({1'b0, prod}) : s1_a_ff[k];
      end
   end

   // Stage two: register scaled values and the threshold decision.
   assign s1_free = !s1_v_ff || s2_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_free) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff && s2_free) begin
         for (int k = 0; k < 4; k++) begin
            s2_a_ff[k] <= scaled[k];
         end
         s2_conf_ff <= s1_conf_ff;
         s2_keep_ff <= (s1_conf_ff >= cfg.score_thr);
         s2_last_ff <= s1_last_ff;
      end
   end

   // Decode center form, clamp to the image, and fall back to corner form.
   always_comb begin
      wq = $signed(DW'({cfg.image_w, 10'b0}));
      hq = $signed(DW'({cfg.image_h, 10'b0}));
      ctr[0] = ((DW'(s2_a_ff[0]) <<< 1) - DW'(s2_a_ff[2])) >>> 1;
      ctr[1] = ((DW'(s2_a_ff[1]) <<< 1) - DW'(s2_a_ff[3])) >>> 1;
      ctr[2] = ((DW'(s2_a_ff[0]) <<< 1) + DW'(s2_a_ff[2])) >>> 1;
      ctr[3] = ((DW'(s2_a_ff[1]) <<< 1) + DW'(s2_a_ff[3])) >>> 1;
      for (int k = 0; k < 4; k++) begin
         crn[k] = DW'(s2_a_ff[k]);
      end
      ctr_c[0] = (ctr[0] < 0) ? '0 : ctr[0];
      ctr_c[1] = (ctr[1] < 0) ? '0 : ctr[1];
      ctr_c[2] = (ctr[2] > wq) ? wq : ctr[2];
      ctr_c[3] = (ctr[3] > hq) ? hq : ctr[3];
      crn_c[0] = (crn[0] < 0) ? '0 : crn[0];
      crn_c[1] = (crn[1] < 0) ? '0 : crn[1];
      crn_c[2] = (crn[2] > wq) ? wq : crn[2];
      crn_c[3] = (crn[3] > hq) ? hq : crn[3];
      ctr_ok = (ctr_c[2] > ctr_c[0]) && (ctr_c[3] > ctr_c[1]);
      crn_ok = (crn_c[2] > crn_c[0]) && (crn_c[3] > crn_c[1]);

      q_data.keep        = s2_keep_ff && (ctr_ok || crn_ok);
      q_data.last_anchor = s2_last_ff;
      q_data.box.score   = s2_conf_ff;
      if (ctr_ok) begin
         q_data.box.x1 = COORD_W'(ctr_c[0]);
         q_data.box.y1 = COORD_W'(ctr_c[1]);
         q_data.box.x2 = COORD_W'(ctr_c[2]);
         q_data.box.y2 = COORD_W'(ctr_c[3]);
      end else begin
         q_data.box.x1 = COORD_W'(crn_c[0]);
         q_data.box.y1 = COORD_W'(crn_c[1]);
         q_data.box.x2 = COORD_W'(crn_c[2]);
         q_data.box.y2 = COORD_W'(crn_c[3]);
      end
   end

   // A request with no box and no frame end is simply dropped.
   assign s2_drop = !q_data.keep && !s2_last_ff;
   assign q_push  = s2_v_ff && !s2_drop && !q_full;
   assign s2_free = !s2_v_ff || s2_drop || !q_full;

endmodule

// ===== rtl/core/bdgn_back.sv =====
// ----------------------------------------------------------------------------
// bdgn_back
// Keeps candidates in a score-sorted store and, at the end of a frame,
// runs greedy overlap suppression and sends the detections.
// ----------------------------------------------------------------------------
module bdgn_back
   import bdgn_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int MAX_OUT  = MAX_OUT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      q_empty,
   input  cand_type                  q_head,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_box_ymin,
   output logic signed [COORD_W-1:0] rsp_box_xmin,
   output logic signed [COORD_W-1:0] rsp_box_ymax,
   output logic signed [COORD_W-1:0] rsp_box_xmax,
   output logic [SCORE_W-1:0]        rsp_score,
   output logic                      rsp_no_detection,
   output logic                      rsp_last_result
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int NW = $clog2(MAX_OUT + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam int UNI_W = AREA_W + 1;
   localparam int CMP_W = UNI_W + SCORE_W;

   // Candidate store and suppression marks.
   box_type     cand_mem [CAPACITY];
   logic        mark_mem [CAPACITY];
   box_type     rd_ff;
   logic        mark_rd_ff;
   logic        rd_en;
   logic [AW-1:0] rd_addr;
   logic        mem_we;
   logic [AW-1:0] mem_wa;
   box_type     mem_wd;
   logic        mark_we;
   logic [AW-1:0] mark_wa;
   logic        mark_wd;

   state_type   state_ff, state_in;
   cand_type    cur_ff, cur_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [NW-1:0] n_ff, n_in;
   logic        held_v_ff, held_v_in;
   box_type     held_ff, held_in;
   logic [AREA_W-1:0] area_i_ff, area_i_in;
   logic [EXT_W-1:0]  w_ff, w_in, h_ff, h_in;
   logic [EXT_W-1:0]  wj_ff, wj_in, hj_ff, hj_in;
   logic        pos_ok_ff, pos_ok_in;
   logic [AREA_W-1:0] inter_ff, inter_in, aj_ff, aj_in;
   logic [UNI_W-1:0]  uni_ff, uni_in;
   logic [CMP_W-1:0]  lhs_ff, lhs_in, rhs_ff, rhs_in;

   logic        out_free, out_push, out_none, out_last;
   box_type     out_box;
   logic [NW-1:0] limit;
   logic [DET_W-1:0] lim7;
   logic [CW-1:0] pos_m1;

   // Effective detection limit: zero acts as one, and MAX_OUT caps it.
   always_comb begin
      lim7 = (cfg.max_det == '0) ? DET_W'(1) : cfg.max_det;
      if (lim7 > DET_W'(MAX_OUT)) begin
         lim7 = DET_W'(MAX_OUT);
      end
      limit = NW'(lim7);
   end

   assign pos_m1   = pos_ff - 1'b1;
   assign out_free = !rsp_valid || !rsp_stall;

   // Sequencer: sorted insertion, then suppression and result delivery.
   always_comb begin
      logic signed [COORD_W-1:0] xx1, yy1, xx2, yy2, dxi, dyi, dxj, dyj;
      logic signed [COORD_W:0]   ww, hh;
      state_in  = state_ff;
      cur_in    = cur_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      n_in      = n_ff;
      held_v_in = held_v_ff;
      held_in   = held_ff;
      area_i_in = area_i_ff;
      w_in      = w_ff;
      h_in      = h_ff;
      wj_in     = wj_ff;
      hj_in     = hj_ff;
      pos_ok_in = pos_ok_ff;
      inter_in  = inter_ff;
      aj_in     = aj_ff;
      uni_in    = uni_ff;
      lhs_in    = lhs_ff;
      rhs_in    = rhs_ff;
      q_pop     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      mem_we    = 1'b0;
      mem_wa    = pos_ff[AW-1:0];
      mem_wd    = cur_ff.box;
      mark_we   = 1'b0;
      mark_wa   = pos_ff[AW-1:0];
      mark_wd   = 1'b0;
      out_push  = 1'b0;
      out_none  = 1'b0;
      out_last  = 1'b0;
      out_box   = held_ff;
      dxi = held_ff.x2 - held_ff.x1;
      dyi = held_ff.y2 - held_ff.y1;
      dxj = rd_ff.x2 - rd_ff.x1;
      dyj = rd_ff.y2 - rd_ff.y1;
      xx1 = (held_ff.x1 > rd_ff.x1) ? held_ff.x1 : rd_ff.x1;
      yy1 = (held_ff.y1 > rd_ff.y1) ? held_ff.y1 : rd_ff.y1;
      xx2 = (held_ff.x2 < rd_ff.x2) ? held_ff.x2 : rd_ff.x2;
      yy2 = (held_ff.y2 < rd_ff.y2) ? held_ff.y2 : rd_ff.y2;
      ww  = (COORD_W+1)'(xx2) - (COORD_W+1)'(xx1);
      hh  = (COORD_W+1)'(yy2) - (COORD_W+1)'(yy1);

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               if (q_head.keep) begin
                  pos_in   = cnt_ff;
                  state_in = ST_INS_CHK;
               end else begin
                  i_in      = '0;
                  n_in      = '0;
                  held_v_in = 1'b0;
                  state_in  = ST_N_SCAN;
               end
            end
         end
         // Walk down from the end while stored scores are lower.
         ST_INS_CHK: begin
            if (pos_ff == '0) begin
               state_in = ST_INS_PUT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = pos_m1[AW-1:0];
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (rd_ff.score < cur_ff.box.score) begin
               if (pos_ff < CAP_C) begin
                  mem_we  = 1'b1;
                  mem_wd  = rd_ff;
                  mark_we = 1'b1;
               end
               pos_in   = pos_m1;
               state_in = ST_INS_CHK;
            end else begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: begin
            if (pos_ff < CAP_C) begin
               mem_we  = 1'b1;
               mark_we = 1'b1;
            end
            if (cnt_ff < CAP_C) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (cur_ff.last_anchor) begin
               i_in      = '0;
               n_in      = '0;
               held_v_in = 1'b0;
               state_in  = ST_N_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         // Find the next candidate that is not suppressed.
         ST_N_SCAN: begin
            if (i_ff >= cnt_ff) begin
               state_in = ST_N_END;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = i_ff[AW-1:0];
               state_in = ST_N_LOAD;
            end
         end
         ST_N_LOAD: begin
            if (mark_rd_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_N_SCAN;
            end else if (held_v_ff) begin
               state_in = ST_N_PUSH;
            end else begin
               state_in = ST_N_TAKE;
            end
         end
         // The previous detection is known not to be the last one.
         ST_N_PUSH: begin
            if (out_free) begin
               out_push = 1'b1;
               state_in = ST_N_TAKE;
            end
         end
         ST_N_TAKE: begin
            held_in   = rd_ff;
            held_v_in = 1'b1;
            n_in      = n_ff + 1'b1;
            if (n_ff + 1'b1 >= limit) begin
               state_in = ST_N_FINAL;
            end else begin
               state_in = ST_N_AREA;
            end
         end
         ST_N_AREA: begin
            area_i_in = dxi[EXT_W-1:0] * dyi[EXT_W-1:0];
            j_in      = i_ff + 1'b1;
            state_in  = ST_N_JRD;
         end
         // Compare the kept box with each later candidate.
         ST_N_JRD: begin
            if (j_ff >= cnt_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_N_SCAN;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = j_ff[AW-1:0];
               state_in = ST_N_J1;
            end
         end
         ST_N_J1: begin
            if (mark_rd_ff) begin
               j_in     = j_ff + 1'b1;
               state_in = ST_N_JRD;
            end else begin
               pos_ok_in = (ww > 0) && (hh > 0);
               w_in      = ww[EXT_W-1:0];
               h_in      = hh[EXT_W-1:0];
               wj_in     = dxj[EXT_W-1:0];
               hj_in     = dyj[EXT_W-1:0];
               state_in  = ST_N_J2;
            end
         end
         ST_N_J2: begin
            inter_in = w_ff * h_ff;
            aj_in    = wj_ff * hj_ff;
            state_in = ST_N_J3;
         end
         ST_N_J3: begin
            uni_in   = UNI_W'(area_i_ff) + UNI_W'(aj_ff) - UNI_W'(inter_ff);
            lhs_in   = CMP_W'({inter_ff, 16'h0000});
            state_in = ST_N_J4;
         end
         ST_N_J4: begin
            rhs_in   = cfg.overlap_thr * uni_ff;
            state_in = ST_N_J5;
         end
         ST_N_J5: begin
            if (pos_ok_ff && (lhs_ff > rhs_ff)) begin
               mark_we = 1'b1;
               mark_wa = j_ff[AW-1:0];
               mark_wd = 1'b1;
            end
            j_in     = j_ff + 1'b1;
            state_in = ST_N_JRD;
         end
         ST_N_END: begin
            state_in = held_v_ff ? ST_N_FINAL : ST_N_EMPTY;
         end
         ST_N_FINAL: begin
            if (out_free) begin
               out_push = 1'b1;
               out_last = 1'b1;
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_N_EMPTY: begin
            if (out_free) begin
               out_push = 1'b1;
               out_none = 1'b1;
               out_last = 1'b1;
               out_box  = '0;
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Working registers of the sequencer.
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      pos_ff    <= pos_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      n_ff      <= n_in;
      held_v_ff <= held_v_in;
      held_ff   <= held_in;
      area_i_ff <= area_i_in;
      w_ff      <= w_in;
      h_ff      <= h_in;
      wj_ff     <= wj_in;
      hj_ff     <= hj_in;
      pos_ok_ff <= pos_ok_in;
      inter_ff  <= inter_in;
      aj_ff     <= aj_in;
      uni_ff    <= uni_in;
      lhs_ff    <= lhs_in;
      rhs_ff    <= rhs_in;
   end

   // Store memories with registered reads.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cand_mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_ff <= cand_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      if (rd_en) begin
         mark_rd_ff <= mark_mem[rd_addr];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (out_push) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         rsp_box_ymin     <= out_box.y1;
         rsp_box_xmin     <= out_box.x1;
         rsp_box_ymax     <= out_box.y2;
         rsp_box_xmax     <= out_box.x2;
         rsp_score        <= out_box.score;
         rsp_no_detection <= out_none;
         rsp_last_result  <= out_last;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CAP_C)
      else $error("candidate count beyond capacity");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_push |-> out_free)
      else $error("result overwritten while waiting");

   a_new_unmarked: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mark_we && !mark_wd && mark_wa == mem_wa))
      else $error("stored candidate not cleared of suppression");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_last) |=> (state_ff == ST_IDLE && cnt_ff == '0))
      else $error("store not emptied after the last result");
`endif

endmodule

// ===== rtl/core/box_decode_greedy_nms.sv =====
// ----------------------------------------------------------------------------
// box_decode_greedy_nms
// Single-class box decoder with a score-sorted candidate store and greedy
// overlap suppression.
// ----------------------------------------------------------------------------
// The front part takes one anchor request per cycle while req_stall is low
// into a two-stage pipeline and queues decoded candidates; the back part
// inserts each one into the sorted store by walking down from its end, one
// stored candidate with a lower score at a time, since the store is one
// memory with a single read port. After the request marked as the last of
// the frame, suppression compares each kept box with every later
// unsuppressed candidate, one pair at a time, and results leave one at a
// time through an output register. No clearing pass is needed after reset.
module box_decode_greedy_nms
   import bdgn_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int MAX_OUT  = MAX_OUT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_AW-1:0]         csr_addr,
   input  logic [CSR_DW-1:0]         csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_anchor_a0,
   input  logic signed [COORD_W-1:0] req_anchor_a1,
   input  logic signed [COORD_W-1:0] req_anchor_a2,
   input  logic signed [COORD_W-1:0] req_anchor_a3,
   input  logic signed [CONF_W-1:0]  req_confidence_raw,
   input  logic                      req_final_anchor,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_box_ymin,
   output logic signed [COORD_W-1:0] rsp_box_xmin,
   output logic signed [COORD_W-1:0] rsp_box_ymax,
   output logic signed [COORD_W-1:0] rsp_box_xmax,
   output logic [SCORE_W-1:0]        rsp_score,
   output logic                      rsp_no_detection,
   output logic                      rsp_last_result
);

   cfg_type  cfg_ff;
   logic     q_push, q_full, q_pop, q_empty;
   cand_type q_data, q_head;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_thr   <= SCORE_THR_RST;
         cfg_ff.overlap_thr <= OVERLAP_THR_RST;
         cfg_ff.max_det     <= MAX_DET_RST;
         cfg_ff.image_w     <= IMAGE_DIM_RST;
         cfg_ff.image_h     <= IMAGE_DIM_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SCORE_THR:   cfg_ff.score_thr   <= csr_wdata;
            CSR_OVERLAP_THR: cfg_ff.overlap_thr <= csr_wdata;
            CSR_MAX_DET:     cfg_ff.max_det     <= csr_wdata[DET_W-1:0];
            CSR_IMAGE_W:     cfg_ff.image_w     <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_H:     cfg_ff.image_h     <= csr_wdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   bdgn_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_anchor_a0      (req_anchor_a0),
      .req_anchor_a1      (req_anchor_a1),
      .req_anchor_a2      (req_anchor_a2),
      .req_anchor_a3      (req_anchor_a3),
      .req_confidence_raw (req_confidence_raw),
      .req_final_anchor   (req_final_anchor),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_data             (q_data)
   );

   bdgn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   bdgn_back #(
      .CAPACITY (CAPACITY),
      .MAX_OUT  (MAX_OUT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_box_ymin     (rsp_box_ymin),
      .rsp_box_xmin     (rsp_box_xmin),
      .rsp_box_ymax     (rsp_box_ymax),
      .rsp_box_xmax     (rsp_box_xmax),
      .rsp_score        (rsp_score),
      .rsp_no_detection (rsp_no_detection),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

// ===== tb/box_decode_greedy_nms_test.sv =====
// ----------------------------------------------------------------------------
// box_decode_greedy_nms_test
// Self-checking bench for the box decoder with greedy overlap suppression.
// Anchor requests go in as frames. A behavioral predictor decodes each
// request, keeps its own sorted candidate list and runs the suppression when
// the last anchor of a frame is taken. Each result is checked field by field
// against the oldest predicted detection. Both sides idle at random.
// ----------------------------------------------------------------------------
module box_decode_greedy_nms_test;
   import bdgn_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int DET_LIMIT   = 64;

   // Candidate as kept by the predictor.
   typedef struct {
      longint x1, y1, x2, y2;
      int     score;
   } cand_entry;

   // One expected detection.
   typedef struct {
      logic [COORD_W-1:0] ymin, xmin, ymax, xmax;
      logic [SCORE_W-1:0] score;
      logic               none, last;
   } det_entry;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_W-1:0] req_anchor_a0 = '0, req_anchor_a1 = '0;
   logic signed [COORD_W-1:0] req_anchor_a2 = '0, req_anchor_a3 = '0;
   logic signed [CONF_W-1:0]  req_confidence_raw = '0;
   logic req_final_anchor = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [COORD_W-1:0] rsp_box_ymin, rsp_box_xmin, rsp_box_ymax, rsp_box_xmax;
   logic [SCORE_W-1:0] rsp_score;
   logic rsp_no_detection, rsp_last_result;

   // Predictor state and configuration copy.
   int unsigned thr_score, thr_overlap, det_max, img_w, img_h;
   cand_entry   ranked[$];
   det_entry    pending_dets[$];
   bit          failed = 1'b0;

   // Sender burst and receiver hold-off control.
   int burst_left = 0;
   int hold_cycles = 0;

   box_decode_greedy_nms i_dut (.*);

   always #2 clock = ~clock;

   // Score of a raw confidence: probability when near 0..1, else a logit.
   function automatic int unsigned score_of(longint raw);
      longint mag, y;
      if (raw >= -2 && raw <= 258) begin
         y = raw * 256;
      end else begin
         mag = raw < 0 ? -raw : raw;
         if (mag < 256) y = 64 * mag + 32768;
         else if (mag < 608) y = 32 * mag + 40960;
         else if (mag < 1280) y = 8 * mag + 55296;
         else y = 65536;
         if (raw < 0) y = 65536 - y;
      end
      if (y < 0) y = 0;
      if (y > 65535) y = 65535;
      return int'(y);
   endfunction

   // Clamp a corner box to the image; returns whether it is non-empty.
   function automatic bit fit_to_image(ref longint b[4]);
      if (b[0] < 0) b[0] = 0;
      if (b[1] < 0) b[1] = 0;
      if (b[2] > longint'(img_w) * 1024) b[2] = longint'(img_w) * 1024;
      if (b[3] > longint'(img_h) * 1024) b[3] = longint'(img_h) * 1024;
      return b[2] > b[0] && b[3] > b[1];
   endfunction

   // Insert into the score-ordered list; equal scores keep arrival order.
   function automatic void rank_candidate(longint b[4], int s);
      cand_entry c;
      int pos;
      pos = ranked.size();
      while (pos > 0 && ranked[pos-1].score < s) pos--;
      if (pos >= STORE_DEPTH) return;
      c.x1 = b[0]; c.y1 = b[1]; c.x2 = b[2]; c.y2 = b[3]; c.score = s;
      ranked.insert(pos, c);
      if (ranked.size() > STORE_DEPTH) void'(ranked.pop_back());
   endfunction

   // True when the later box overlaps the kept one above the threshold.
   function automatic bit overlap_hit(cand_entry p, cand_entry q);
      longint w, h, inter, uni;
      w = (p.x2 < q.x2 ? p.x2 : q.x2) - (p.x1 > q.x1 ? p.x1 : q.x1);
      h = (p.y2 < q.y2 ? p.y2 : q.y2) - (p.y1 > q.y1 ? p.y1 : q.y1);
      if (w <= 0 || h <= 0) return 1'b0;
      inter = w * h;
      uni = (p.x2 - p.x1) * (p.y2 - p.y1) + (q.x2 - q.x1) * (q.y2 - q.y1) - inter;
      return inter * 65536 > longint'(thr_overlap) * uni;
   endfunction

   // Decode one accepted request and, at frame end, predict the detections.
   function automatic void predict_anchor(longint a0, longint a1, longint a2,
                                          longint a3, longint raw, bit fin);
      longint a[4], b[4];
      bit norm;
      int unsigned conf, lim;
      bit cut[];
      det_entry d;
      int n;
      a[0] = a0; a[1] = a1; a[2] = a2; a[3] = a3;
      norm = 1'b1;
      foreach (a[k]) if (a[k] < 0 || a[k] > 1536) norm = 1'b0;
      conf = score_of(raw);
      if (conf >= thr_score) begin
         if (norm) begin
            a[0] *= img_w; a[2] *= img_w; a[1] *= img_h; a[3] *= img_h;
         end
         b[0] = (2 * a[0] - a[2]) >>> 1;
         b[1] = (2 * a[1] - a[3]) >>> 1;
         b[2] = (2 * a[0] + a[2]) >>> 1;
         b[3] = (2 * a[1] + a[3]) >>> 1;
         if (fit_to_image(b)) begin
            rank_candidate(b, conf);
         end else begin
            b = a;
            if (fit_to_image(b)) rank_candidate(b, conf);
         end
      end
      if (!fin) return;
      lim = det_max == 0 ? 1 : (det_max > DET_LIMIT ? DET_LIMIT : det_max);
      cut = new[ranked.size()];
      n = 0;
      foreach (ranked[i]) begin
         if (cut[i]) continue;
         d.xmin = ranked[i].x1[COORD_W-1:0]; d.ymin = ranked[i].y1[COORD_W-1:0];
         d.xmax = ranked[i].x2[COORD_W-1:0]; d.ymax = ranked[i].y2[COORD_W-1:0];
         d.score = ranked[i].score[SCORE_W-1:0];
         d.none = 1'b0; d.last = 1'b0;
         pending_dets.insert(pending_dets.size(), d);
         n++;
         if (n >= lim) break;
         for (int j = i + 1; j < ranked.size(); j++)
            if (!cut[j] && overlap_hit(ranked[i], ranked[j])) cut[j] = 1'b1;
      end
      if (n == 0) begin
         d = '{default: '0};
         d.none = 1'b1; d.last = 1'b1;
         pending_dets.insert(pending_dets.size(), d);
      end else begin
         pending_dets[$].last = 1'b1;
      end
      ranked.delete();
   endfunction

   // Send one anchor request; called and returning at a falling edge.
   task automatic send_anchor(longint a0, longint a1, longint a2, longint a3,
                              longint raw, bit fin);
      req_anchor_a0 <= a0[COORD_W-1:0]; req_anchor_a1 <= a1[COORD_W-1:0];
      req_anchor_a2 <= a2[COORD_W-1:0]; req_anchor_a3 <= a3[COORD_W-1:0];
      req_confidence_raw <= raw[CONF_W-1:0];
      req_final_anchor <= fin;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_anchor(a0, a1, a2, a3, raw, fin);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   endtask

   // Drop the request valid and wait until all detections are in.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_dets.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   // Write one register while the block is idle.
   task automatic write_reg(csr_index_type idx, int unsigned val);
      csr_we <= 1'b1; csr_addr <= idx; csr_wdata <= val[CSR_DW-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_SCORE_THR:   thr_score = val & 16'hFFFF;
         CSR_OVERLAP_THR: thr_overlap = val & 16'hFFFF;
         CSR_MAX_DET:     det_max = val & 7'h7F;
         CSR_IMAGE_W:     img_w = val & 12'hFFF;
         default:         img_h = val & 12'hFFF;
      endcase
   endtask

   task automatic set_config(int unsigned st, int unsigned ov, int unsigned md,
                             int unsigned w, int unsigned h);
      write_reg(CSR_SCORE_THR, st);
      write_reg(CSR_OVERLAP_THR, ov);
      write_reg(CSR_MAX_DET, md);
      write_reg(CSR_IMAGE_W, w);
      write_reg(CSR_IMAGE_H, h);
   endtask

   // Pixel-form anchor in Q13.10 from whole pixels.
   task automatic send_px(int cx, int cy, int w, int h, int raw, bit fin);
      send_anchor(cx * 1024, cy * 1024, w * 1024, h * 1024, raw, fin);
   endtask

   // One random anchor: mostly well-formed boxes near a few cluster centers,
   // some normalized, some logits and some raw noise.
   task automatic send_random_anchor(int cx, int cy, bit fin);
      int unsigned sel;
      longint raw;
      sel = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) begin
         raw = longint'($signed(16'($urandom_range(0, 65535))));
      end else begin
         raw = longint'($urandom_range(0, 258));
      end
      if (sel < 6) begin
         send_anchor(cx * 1024 + int'($urandom_range(0, 8191)) - 4096,
                     cy * 1024 + int'($urandom_range(0, 8191)) - 4096,
                     $urandom_range(1024, 80 * 1024), $urandom_range(1024, 80 * 1024),
                     raw, fin);
      end else if (sel < 8) begin
         send_anchor($urandom_range(0, 1536), $urandom_range(0, 1536),
                     $urandom_range(0, 1536), $urandom_range(0, 1536), raw, fin);
      end else begin
         send_anchor($signed(24'($urandom)), $signed(24'($urandom)),
                     $signed(24'($urandom)), $signed(24'($urandom)), raw, fin);
      end
   endtask

   task automatic send_random_frame(int len);
      int cx[3], cy[3];
      int k;
      foreach (cx[i]) begin
         cx[i] = $urandom_range(0, 330);
         cy[i] = $urandom_range(0, 330);
      end
      for (int i = 0; i < len; i++) begin
         k = $urandom_range(0, 2);
         send_random_anchor(cx[k], cy[k], i == len - 1);
      end
   endtask

   // Field extremes, every sigmoid segment and the listed corner cases.
   task automatic test_directed();
      set_config(0, 29491, 64, 320, 320);
      send_anchor(-8388608, -8388608, -8388608, -8388608, -32768, 1'b0);
      send_anchor(8388607, 8388607, 8388607, 8388607, 32767, 1'b0);
      send_px(40, 40, 20, 20, -3, 1'b0);
      send_px(80, 40, 20, 20, -2, 1'b0);
      send_px(120, 40, 20, 20, 255, 1'b0);
      send_px(160, 40, 20, 20, 258, 1'b0);
      send_px(200, 40, 20, 20, 259, 1'b0);
      send_px(240, 40, 20, 20, 607, 1'b0);
      send_px(280, 40, 20, 20, 608, 1'b0);
      send_px(40, 120, 20, 20, 1279, 1'b0);
      send_px(80, 120, 20, 20, 1280, 1'b0);
      send_px(120, 120, 20, 20, -700, 1'b0);
      // Normalized box, and a box that is empty in center form only.
      send_anchor(512, 512, 256, 256, 200, 1'b0);
      send_px(-100, -100, 50, 50, 220, 1'b0);
      // Equal scores and overlapping pairs.
      send_px(200, 200, 40, 40, 180, 1'b0);
      send_px(202, 202, 40, 40, 180, 1'b0);
      send_px(260, 260, 60, 60, 180, 1'b0);
      send_px(300, 300, 60, 60, 170, 1'b1);
      wait_idle();
      // Empty frame.
      send_px(10, 10, 0, 0, 100, 1'b1);
      wait_idle();
   endtask

   // Block fills up while the output is held off.
   task automatic test_backpressure();
      set_config(16384, 32768, 64, 320, 320);
      send_random_frame(12);
      hold_cycles = 600;
      send_random_frame(30);
      wait_idle();
   endtask

   // More candidates than the store holds; the lowest are lost.
   task automatic test_full_store();
      set_config(0, 29491, 3, 320, 320);
      for (int i = 0; i < STORE_DEPTH + 6; i++)
         send_px(10 + i % 300, 10 + (i / 300) * 60, 8, 8,
                 (i < 8) ? 100 + i : ((i > STORE_DEPTH) ? 50 + i % 4 : 120), 1'b0);
      send_px(100, 100, 8, 8, 60, 1'b1);
      wait_idle();
   endtask

   // Random frames under a range of register settings.
   task automatic test_random();
      int unsigned st[8] = '{32768, 0, 65535, 16384, 0, 20000, 32768, 40000};
      int unsigned ov[8] = '{29491, 0, 65535, 20000, 45000, 29491, 10000, 65535};
      int unsigned md[8] = '{10, 1, 64, 0, 127, 5, 64, 20};
      int unsigned iw[8] = '{320, 1, 4095, 0, 320, 640, 200, 4095};
      int unsigned ih[8] = '{320, 4095, 1, 320, 0, 480, 300, 4095};
      for (int p = 0; p < 8; p++) begin
         set_config(st[p], ov[p], md[p], iw[p], ih[p]);
         for (int f = 0; f < 4; f++) send_random_frame($urandom_range(2, 18));
         wait_idle();
      end
   endtask

   // Receiver stall pattern, with long hold-offs on request.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (($time / 800) % 3 == 0) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
      end
   end

   // Compare each accepted result with the oldest expected detection.
   always @(posedge clock) begin
      det_entry d;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_dets.size() == 0) begin
            $display("%0t: unexpected result ymin=%h xmin=%h score=%h", $time,
                     rsp_box_ymin, rsp_box_xmin, rsp_score);
            failed = 1'b1;
         end else begin
            d = pending_dets.pop_front();
            if (rsp_box_ymin !== d.ymin || rsp_box_xmin !== d.xmin ||
                rsp_box_ymax !== d.ymax || rsp_box_xmax !== d.xmax ||
                rsp_score !== d.score || rsp_no_detection !== d.none ||
                rsp_last_result !== d.last) begin
               $display("%0t: expected box %h %h %h %h score %h none %b last %b",
                        $time, d.ymin, d.xmin, d.ymax, d.xmax, d.score, d.none, d.last);
               $display("%0t: actual   box %h %h %h %h score %h none %b last %b",
                        $time, rsp_box_ymin, rsp_box_xmin, rsp_box_ymax, rsp_box_xmax,
                        rsp_score, rsp_no_detection, rsp_last_result);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      thr_score = SCORE_THR_RST; thr_overlap = OVERLAP_THR_RST;
      det_max = MAX_DET_RST; img_w = IMAGE_DIM_RST; img_h = IMAGE_DIM_RST;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // Frame under the reset configuration first.
      send_random_frame(10);
      wait_idle();
      test_directed();
      test_backpressure();
      test_random();
      test_full_store();
      set_config(32768, 29491, 10, 320, 320);
      for (int f = 0; f < 8; f++) send_random_frame($urandom_range(4, 16));
      wait_idle();
      repeat (50) @(negedge clock);
      if (!failed && pending_dets.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/bdgn_pkg.sv
rtl/core/bdgn_queue.sv
rtl/core/bdgn_front.sv
rtl/core/bdgn_back.sv
rtl/core/box_decode_greedy_nms.sv
tb/box_decode_greedy_nms_test.sv
